FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. Building with SYNTH defined drops them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property that must hold on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion %m failed");
// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion %m failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/tlcc_pkg.sv
`default_nettype none

package tlcc_pkg;

    // Widths fixed by the item and register formats
    localparam int TIMER_WIDTH_DEF = 16;
    localparam int CFG_W           = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int CODE_W          = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUSY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RINGBACK = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RING     = 2'd3;

    // Register reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_DEF = 16'd300;
    localparam logic [CFG_W-1:0] BUSY_DEF     = 16'd500;
    localparam logic [CFG_W-1:0] RINGBACK_DEF = 16'd4000;
    localparam logic [CFG_W-1:0] RING_DEF     = 16'd2000;

    // Call state codes as seen on the result
    localparam logic [CODE_W-1:0] CS_IDLE      = 3'd0;
    localparam logic [CODE_W-1:0] CS_BUSY      = 3'd1;
    localparam logic [CODE_W-1:0] CS_WAIT      = 3'd2;
    localparam logic [CODE_W-1:0] CS_CALLING   = 3'd3;
    localparam logic [CODE_W-1:0] CS_CONNECTED = 3'd4;

    // Tone commands
    localparam logic [CODE_W-1:0] TONE_NONE     = 3'd0;
    localparam logic [CODE_W-1:0] TONE_STOP     = 3'd1;
    localparam logic [CODE_W-1:0] TONE_DIAL     = 3'd2;
    localparam logic [CODE_W-1:0] TONE_BUSY     = 3'd3;
    localparam logic [CODE_W-1:0] TONE_RINGBACK = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_BUSY      = 5'b00010,
        ST_WAIT      = 5'b00100,
        ST_CALLING   = 5'b01000,
        ST_CONNECTED = 5'b10000
    } call_state_t;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] busy_cadence_ms;
        logic [CFG_W-1:0] ringback_cadence_ms;
        logic [CFG_W-1:0] ring_toggle_ms;
    } cfg_t;

    typedef struct packed {
        logic caller;
        logic dest;
    } hooks_t;

    typedef struct packed {
        logic [CODE_W-1:0] call_state;
        logic              join_relay;
        logic              bell_relay;
        logic [CODE_W-1:0] tone_command;
        logic              send_caller_id;
    } result_t;

    // One-hot state to result code
    function automatic logic [CODE_W-1:0] state_code(call_state_t st);
        logic [CODE_W-1:0] code;
        case (st)
            ST_BUSY:      code = CS_BUSY;
            ST_WAIT:      code = CS_WAIT;
            ST_CALLING:   code = CS_CALLING;
            ST_CONNECTED: code = CS_CONNECTED;
            default:      code = CS_IDLE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tlcc_ifs.sv
`default_nettype none

// Tick item channel
interface tlcc_tick_if;
    logic valid;
    logic ready;
    logic caller_hook_raw;
    logic dest_hook_raw;
    logic digits_received;

    modport source (output valid, caller_hook_raw, dest_hook_raw, digits_received,
                    input ready);
    modport sink   (input valid, caller_hook_raw, dest_hook_raw, digits_received,
                    output ready);
endinterface

// Result item channel
interface tlcc_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] call_state;
    logic       join_relay;
    logic       bell_relay;
    logic [2:0] tone_command;
    logic       send_caller_id;

    modport source (output valid, call_state, join_relay, bell_relay, tone_command,
                    send_caller_id, input ready);
    modport sink   (input valid, call_state, join_relay, bell_relay, tone_command,
                    send_caller_id, output ready);
endinterface

// Register write channel
interface tlcc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tlcc_debounce.sv
`default_nettype none

module tlcc_debounce
    import tlcc_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire logic             raw,
    input  wire logic [CFG_W-1:0] debounce_ms,
    output logic                  stable
);

    localparam int CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

    logic                   seen_reg;
    logic                   stable_reg;
    logic [TIMER_WIDTH-1:0] quiet_reg;
    logic [TIMER_WIDTH-1:0] quiet_next;

    // Level change restarts the quiet count, otherwise count up and hold at max
    always_comb
    begin
        if (raw != seen_reg)
            quiet_next = '0;
        else if (quiet_reg == '1)
            quiet_next = quiet_reg;
        else
            quiet_next = TIMER_WIDTH'(quiet_reg + 1'b1);
    end

    // Level quiet long enough becomes the accepted level for this tick
    assign stable = (CMP_W'(quiet_next) > CMP_W'(debounce_ms)) ? raw : stable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg   <= 1'b0;
            stable_reg <= 1'b0;
            quiet_reg  <= '0;
        end
        else if (advance)
        begin
            seen_reg   <= raw;
            stable_reg <= stable;
            quiet_reg  <= quiet_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tlcc_engine.sv
`default_nettype none

module tlcc_engine
    import tlcc_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   advance,
    input  wire logic   digits,
    input  wire hooks_t hooks,
    input  wire cfg_t   cfg,
    output result_t     res
);

    localparam int CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

    call_state_t            state_reg, state_next;
    logic [TIMER_WIDTH-1:0] tone_el_reg, tone_el_next, tone_inc;
    logic [TIMER_WIDTH-1:0] ring_el_reg, ring_el_next, ring_inc;
    logic [1:0]             ring_cnt_reg, ring_cnt_next;
    logic                   ringer_reg, ringer_next;
    logic [CODE_W-1:0]      tone;
    logic                   cid;
    logic                   leaving;

    // Saturating tick timers
    assign tone_inc = (tone_el_reg == '1) ? tone_el_reg : TIMER_WIDTH'(tone_el_reg + 1'b1);
    assign ring_inc = (ring_el_reg == '1) ? ring_el_reg : TIMER_WIDTH'(ring_el_reg + 1'b1);

    // Call state transitions on the debounced hook levels
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_BUSY:
            begin
                if (!hooks.caller && !hooks.dest)
                    state_next = ST_IDLE;
            end
            ST_WAIT:
            begin
                if (!hooks.caller)
                    state_next = ST_IDLE;
                else if (digits)
                    state_next = ST_CALLING;
            end
            ST_CALLING:
            begin
                if (!hooks.caller)
                    state_next = ST_IDLE;
                else if (hooks.dest)
                    state_next = ST_CONNECTED;
            end
            ST_CONNECTED:
            begin
                if (!hooks.caller)
                    state_next = ST_BUSY;
            end
            default:
            begin
                if (hooks.caller && hooks.dest)
                    state_next = ST_BUSY;
                else if (hooks.caller)
                    state_next = ST_WAIT;
                else
                    state_next = ST_IDLE;
            end
        endcase
    end

    assign leaving = ((state_reg == ST_BUSY) || (state_reg == ST_CALLING) ||
                      (state_reg == ST_WAIT)) && (state_next != state_reg);

    // Exit, tone and ringer actions; later commands override earlier ones
    always_comb
    begin
        tone          = TONE_NONE;
        cid           = 1'b0;
        tone_el_next  = tone_inc;
        ring_el_next  = ring_inc;
        ringer_next   = ringer_reg;
        ring_cnt_next = (state_reg == ST_WAIT) ? 2'd0 : ring_cnt_reg;

        if (leaving)
        begin
            tone         = TONE_STOP;
            ringer_next  = 1'b0;
            tone_el_next = '1;
        end
        if ((state_next == ST_WAIT) && (state_reg != ST_WAIT))
            tone = TONE_DIAL;
        if ((state_next == ST_BUSY) && (CMP_W'(tone_el_next) > CMP_W'(cfg.busy_cadence_ms)))
        begin
            tone         = TONE_BUSY;
            tone_el_next = '0;
        end
        if (state_next == ST_CALLING)
        begin
            if (CMP_W'(tone_el_next) > CMP_W'(cfg.ringback_cadence_ms))
            begin
                tone         = TONE_RINGBACK;
                tone_el_next = '0;
            end
            if (CMP_W'(ring_inc) > CMP_W'(cfg.ring_toggle_ms))
            begin
                cid          = (ring_cnt_next == 2'd1);
                ringer_next  = !ringer_next;
                ring_el_next = '0;
                if (ring_cnt_next != 2'd3)
                    ring_cnt_next = 2'(ring_cnt_next + 1'b1);
            end
        end
        if (state_next == ST_CONNECTED)
            ringer_next = 1'b0;
    end

    // Result of this tick
    always_comb
    begin
        res.call_state     = state_code(state_next);
        res.join_relay     = (state_next == ST_CONNECTED);
        res.bell_relay     = ringer_next;
        res.tone_command   = tone;
        res.send_caller_id = cid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            tone_el_reg  <= '1;
            ring_el_reg  <= '1;
            ring_cnt_reg <= 2'd0;
            ringer_reg   <= 1'b0;
        end
        else if (advance)
        begin
            state_reg    <= state_next;
            tone_el_reg  <= tone_el_next;
            ring_el_reg  <= ring_el_next;
            ring_cnt_reg <= ring_cnt_next;
            ringer_reg   <= ringer_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/two_line_call_controller_core.sv
`default_nettype none
`include "assert_macros.svh"

// Call controller for two phone lines, one tick item per millisecond. Each tick
// item is captured in an input register, then hook debouncing, the call state
// machine and the tone/ringer timers are evaluated in one pass into a result
// register, so it takes one item per clock while results are taken; a tick
// moves on when the result register is empty or being read. While a
// result is stalled, one more tick is held in the input register before
// tick.ready drops. Hook levels are accepted after staying
// unchanged for more than debounce_ms ticks; cadence and ring timers are
// TIMER_WIDTH bits and saturate, so a register setting at or above the timer
// maximum disables its event. Registers are written through cfg, which is always
// ready, and should only be changed while no tick is in flight.
module two_line_call_controller_core
    import tlcc_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    tlcc_tick_if.sink       tick,
    tlcc_result_if.source   result,
    tlcc_cfg_if.sink        cfg
);

    cfg_t    cfg_reg;
    logic    tick_valid_reg;
    logic    caller_raw_reg;
    logic    dest_raw_reg;
    logic    digits_reg;
    logic    result_valid_reg;
    result_t result_reg;
    result_t res;
    hooks_t  hooks;
    logic    caller_stable;
    logic    dest_stable;
    logic    advance;

    // Register writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms         <= DEBOUNCE_DEF;
            cfg_reg.busy_cadence_ms     <= BUSY_DEF;
            cfg_reg.ringback_cadence_ms <= RINGBACK_DEF;
            cfg_reg.ring_toggle_ms      <= RING_DEF;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_DEBOUNCE: cfg_reg.debounce_ms         <= cfg.data;
                REG_BUSY:     cfg_reg.busy_cadence_ms     <= cfg.data;
                REG_RINGBACK: cfg_reg.ringback_cadence_ms <= cfg.data;
                REG_RING:     cfg_reg.ring_toggle_ms      <= cfg.data;
                default:      cfg_reg                     <= cfg_reg;
            endcase
        end
    end

    // Pipeline control: input stage moves when the result register is free
    assign advance    = tick_valid_reg && (!result_valid_reg || result.ready);
    assign tick.ready = !tick_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_valid_reg <= 1'b0;
        else if (tick.ready)
            tick_valid_reg <= tick.valid;
    end

    always_ff @(posedge clk)
    begin
        if (tick.ready && tick.valid)
        begin
            caller_raw_reg <= tick.caller_hook_raw;
            dest_raw_reg   <= tick.dest_hook_raw;
            digits_reg     <= tick.digits_received;
        end
    end

    // Hook debouncers
    tlcc_debounce #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_caller_db (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .raw         (caller_raw_reg),
        .debounce_ms (cfg_reg.debounce_ms),
        .stable      (caller_stable)
    );

    tlcc_debounce #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_dest_db (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .raw         (dest_raw_reg),
        .debounce_ms (cfg_reg.debounce_ms),
        .stable      (dest_stable)
    );

    assign hooks = '{caller: caller_stable, dest: dest_stable};

    // Call state machine and timers
    tlcc_engine #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .digits  (digits_reg),
        .hooks   (hooks),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= 1'b1;
        else if (result.ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= res;
    end

    assign result.valid          = result_valid_reg;
    assign result.call_state     = result_reg.call_state;
    assign result.join_relay     = result_reg.join_relay;
    assign result.bell_relay     = result_reg.bell_relay;
    assign result.tone_command   = result_reg.tone_command;
    assign result.send_caller_id = result_reg.send_caller_id;

    // Checks
    `ASSERT_ALWAYS(a_connect_only_connected, clk, rst_n,
        !result_valid_reg || (result_reg.join_relay == (result_reg.call_state == CS_CONNECTED)))
    `ASSERT_IMPLIES(a_cid_on_second_ring, clk, rst_n,
        result_valid_reg && result_reg.send_caller_id,
        (result_reg.call_state == CS_CALLING) && !result_reg.bell_relay)
    `ASSERT_IMPLIES(a_dial_in_wait, clk, rst_n,
        result_valid_reg && (result_reg.tone_command == TONE_DIAL),
        result_reg.call_state == CS_WAIT)

endmodule

`default_nettype wire

FILE: tb/two_line_call_controller_core_tb.sv
`default_nettype none

module two_line_call_controller_core_tb;
    import tlcc_pkg::*;

    localparam int TW = TIMER_WIDTH_DEF;
    // previous-state code before the first tick, distinct from every state
    localparam logic [CODE_W-1:0] CS_NONE = 3'd7;
    localparam int RANDOM_TICKS = 450;
    localparam int PHASE_TICKS = 150;
    localparam int DRAIN_LIMIT = 5000;
    localparam int MAX_PRINTS = 100;

    logic clk;
    logic rst_n;

    tlcc_tick_if   tick_ch();
    tlcc_result_if result_ch();
    tlcc_cfg_if    cfg_ch();

    two_line_call_controller_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Call controller predictor plus the queue of outputs still due
    class call_scoreboard;
        cfg_t              regs;
        logic [CODE_W-1:0] cur_state;
        logic [CODE_W-1:0] prior_state;
        bit                caller_seen;
        bit                dest_seen;
        bit                caller_up;
        bit                dest_up;
        bit [TW-1:0]       caller_quiet;
        bit [TW-1:0]       dest_quiet;
        bit [TW-1:0]       tone_timer;
        bit [TW-1:0]       ring_timer;
        bit [1:0]          rings;
        bit                ringer;
        result_t           due_results[$];
        int                errors;
        int                checked;

        function new();
            regs.debounce_ms         = DEBOUNCE_DEF;
            regs.busy_cadence_ms     = BUSY_DEF;
            regs.ringback_cadence_ms = RINGBACK_DEF;
            regs.ring_toggle_ms      = RING_DEF;
            cur_state    = CS_IDLE;
            prior_state  = CS_NONE;
            caller_seen  = 1'b0;
            dest_seen    = 1'b0;
            caller_up    = 1'b0;
            dest_up      = 1'b0;
            caller_quiet = '0;
            dest_quiet   = '0;
            tone_timer   = '1;
            ring_timer   = '1;
            rings        = '0;
            ringer       = 1'b0;
            errors       = 0;
            checked      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_DEBOUNCE: regs.debounce_ms         = val;
                REG_BUSY:     regs.busy_cadence_ms     = val;
                REG_RINGBACK: regs.ringback_cadence_ms = val;
                REG_RING:     regs.ring_toggle_ms      = val;
                default:      ;
            endcase
        endfunction

        function bit [TW-1:0] sat_inc(bit [TW-1:0] t);
            return (t == '1) ? t : t + 1'b1;
        endfunction

        // raw change restarts the quiet count; a long enough quiet period is taken
        function void debounce(bit raw, inout bit seen, inout bit [TW-1:0] quiet,
                               inout bit up);
            if (raw != seen) begin
                seen  = raw;
                quiet = '0;
            end
            else
                quiet = sat_inc(quiet);
            if (quiet > regs.debounce_ms)
                up = seen;
        endfunction

        // one accepted tick item -> one predicted output item
        function void note_tick(bit caller_raw, bit dest_raw, bit digits);
            result_t           r;
            logic [CODE_W-1:0] st;
            logic [CODE_W-1:0] tone;
            bit                cid;
            st   = cur_state;
            tone = TONE_NONE;
            cid  = 1'b0;
            tone_timer = sat_inc(tone_timer);
            ring_timer = sat_inc(ring_timer);
            debounce(caller_raw, caller_seen, caller_quiet, caller_up);
            debounce(dest_raw, dest_seen, dest_quiet, dest_up);

            case (cur_state)
                CS_BUSY:
                begin
                    if (!caller_up && !dest_up)
                        st = CS_IDLE;
                end
                CS_WAIT:
                begin
                    rings = '0;
                    if (!caller_up)
                        st = CS_IDLE;
                    else if (digits)
                        st = CS_CALLING;
                end
                CS_CALLING:
                begin
                    if (!caller_up)
                        st = CS_IDLE;
                    else if (dest_up)
                        st = CS_CONNECTED;
                end
                CS_CONNECTED:
                begin
                    if (!caller_up)
                        st = CS_BUSY;
                end
                default:
                begin
                    if (caller_up && dest_up)
                        st = CS_BUSY;
                    else if (caller_up)
                        st = CS_WAIT;
                    else
                        st = CS_IDLE;
                end
            endcase

            // leaving a toned state: stop, ringer off, cadence due at once
            if ((prior_state == CS_BUSY || prior_state == CS_CALLING ||
                 prior_state == CS_WAIT) && st != prior_state) begin
                tone       = TONE_STOP;
                ringer     = 1'b0;
                tone_timer = '1;
            end
            if (st == CS_WAIT && prior_state != CS_WAIT)
                tone = TONE_DIAL;
            if (st == CS_BUSY && tone_timer > regs.busy_cadence_ms) begin
                tone       = TONE_BUSY;
                tone_timer = '0;
            end
            if (st == CS_CALLING) begin
                if (tone_timer > regs.ringback_cadence_ms) begin
                    tone       = TONE_RINGBACK;
                    tone_timer = '0;
                end
                if (ring_timer > regs.ring_toggle_ms) begin
                    // caller id goes out on the second toggle
                    if (rings == 2'd1)
                        cid = 1'b1;
                    ringer     = ~ringer;
                    ring_timer = '0;
                    if (rings != 2'd3)
                        rings++;
                end
            end
            if (st == CS_CONNECTED)
                ringer = 1'b0;

            cur_state   = st;
            prior_state = st;

            r.call_state     = st;
            r.join_relay     = (st == CS_CONNECTED);
            r.bell_relay     = ringer;
            r.tone_command   = tone;
            r.send_caller_id = cid;
            due_results.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("MISMATCH: %s", msg);
        endtask

        task check_result(result_t got);
            result_t want;
            if (due_results.size() == 0) begin
                report($sformatf("output item with none due (state %0d tone %0d)",
                                 got.call_state, got.tone_command));
                return;
            end
            want = due_results.pop_front();
            if (got.call_state !== want.call_state)
                report($sformatf("item %0d call_state %0d, want %0d",
                                 checked, got.call_state, want.call_state));
            if (got.join_relay !== want.join_relay)
                report($sformatf("item %0d join_relay %0b, want %0b",
                                 checked, got.join_relay, want.join_relay));
            if (got.bell_relay !== want.bell_relay)
                report($sformatf("item %0d bell_relay %0b, want %0b",
                                 checked, got.bell_relay, want.bell_relay));
            if (got.tone_command !== want.tone_command)
                report($sformatf("item %0d tone_command %0d, want %0d",
                                 checked, got.tone_command, want.tone_command));
            if (got.send_caller_id !== want.send_caller_id)
                report($sformatf("item %0d send_caller_id %0b, want %0b",
                                 checked, got.send_caller_id, want.send_caller_id));
            checked++;
        endtask
    endclass

    call_scoreboard sb = new();

    int ticks_sent = 0;
    int tick_burst = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Idle length: mostly none or short, a few long, now and then a gap-free burst
    function automatic int idle_len(inout int burst);
        int p;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        p = $urandom_range(0, 99);
        if (p < 2) begin
            burst = $urandom_range(20, 80);
            return 0;
        end
        if (p < 50)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Hold time that outlasts the debounce window, sometimes by a lot
    function automatic int hold_len(int deb);
        if ($urandom_range(0, 9) == 0)
            return deb + 2 + $urandom_range(10, 60);
        return deb + 2 + $urandom_range(0, 4);
    endfunction

    function automatic logic [CFG_W-1:0] pick_cadence(int hi);
        int p;
        p = $urandom_range(0, 99);
        if (p < 10)
            return '0;
        if (p < 20)
            return '1;
        return CFG_W'($urandom_range(1, hi));
    endfunction

    task automatic send_tick(bit caller_raw, bit dest_raw, bit digits);
        int gap;
        gap = idle_len(tick_burst);
        if (gap > 0) begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_ch.valid           <= 1'b1;
        tick_ch.caller_hook_raw <= caller_raw;
        tick_ch.dest_hook_raw   <= dest_raw;
        tick_ch.digits_received <= digits;
        do @(posedge clk); while (tick_ch.ready !== 1'b1);
        sb.note_tick(caller_raw, dest_raw, digits);
        ticks_sent++;
    endtask

    // n ticks at fixed hook levels, optional single-tick glitches
    task automatic hold_lines(int caller, int dest, int n, int digit_pct, int glitchy);
        bit c;
        bit d;
        for (int i = 0; i < n; i++) begin
            c = (caller != 0);
            d = (dest != 0);
            if (glitchy != 0 && $urandom_range(0, 99) < 6) begin
                if ($urandom_range(0, 1) != 0)
                    c = ~c;
                else
                    d = ~d;
            end
            send_tick(c, d, $urandom_range(0, 99) < digit_pct);
        end
    endtask

    task automatic noise(int n);
        for (int i = 0; i < n; i++)
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 99) < 30);
    endtask

    // Let every output item come back
    task automatic settle();
        int w;
        tick_ch.valid <= 1'b0;
        w = 0;
        while (sb.due_results.size() != 0 && w < DRAIN_LIMIT) begin
            @(posedge clk);
            w++;
        end
        repeat (4) @(posedge clk);
    endtask

    // Write all four registers back to back, valid kept high across them
    task automatic set_regs(logic [CFG_W-1:0] deb, logic [CFG_W-1:0] busy,
                            logic [CFG_W-1:0] ringback, logic [CFG_W-1:0] ring);
        logic [CFG_W-1:0] vals [4];
        vals[REG_DEBOUNCE] = deb;
        vals[REG_BUSY]     = busy;
        vals[REG_RINGBACK] = ringback;
        vals[REG_RING]     = ring;
        for (int i = 0; i < 4; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= CFG_IDX_W'(i);
            cfg_ch.data  <= vals[i];
            do @(posedge clk); while (cfg_ch.ready !== 1'b1);
            sb.write_reg(CFG_IDX_W'(i), vals[i]);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Full call: off hook, dial, ring, answer, hang up; some abandon early
    task automatic call_flow(int deb);
        bit gl;
        gl = $urandom_range(0, 99) < 30;
        hold_lines(1, 0, hold_len(deb), 0, gl);
        if ($urandom_range(0, 99) < 15) begin
            hold_lines(0, 0, hold_len(deb), 5, gl);
            return;
        end
        hold_lines(1, 0, $urandom_range(0, 5), 0, 0);
        hold_lines(1, 0, 1, 100, 0);
        hold_lines(1, 0, $urandom_range(0, 40), 10, 0);
        if ($urandom_range(0, 99) < 20) begin
            hold_lines(0, 0, hold_len(deb), 0, gl);
            return;
        end
        hold_lines(1, 1, hold_len(deb), 10, gl);
        hold_lines(1, 1, $urandom_range(0, 10), 10, 0);
        if ($urandom_range(0, 99) < 50) begin
            hold_lines(0, 1, hold_len(deb), 0, gl);
            hold_lines(0, 1, $urandom_range(0, 30), 10, 0);
        end
        hold_lines(0, 0, hold_len(deb), 0, gl);
    endtask

    // Both lines lifted together from idle: busy, then both down
    task automatic busy_flow(int deb);
        bit gl;
        gl = $urandom_range(0, 99) < 30;
        hold_lines(1, 1, hold_len(deb), 0, gl);
        hold_lines(1, 1, $urandom_range(0, 30), 10, 0);
        hold_lines(0, 0, hold_len(deb), 0, gl);
    endtask

    task automatic random_phase();
        logic [CFG_W-1:0] deb;
        int start;
        int p;
        if ($urandom_range(0, 4) == 0)
            deb = CFG_W'($urandom_range(7, 20));
        else
            deb = CFG_W'($urandom_range(0, 6));
        set_regs(deb, pick_cadence(40), pick_cadence(60), pick_cadence(30));
        start = ticks_sent;
        while (ticks_sent - start < PHASE_TICKS) begin
            p = $urandom_range(0, 99);
            if (p < 60)
                call_flow(deb);
            else if (p < 75)
                busy_flow(deb);
            else
                noise($urandom_range(5, 40));
        end
        settle();
    endtask

    // Output side: ready in runs, stalls mostly short and a few long
    initial
    begin : ready_gen
        int left;
        int burst;
        left  = 0;
        burst = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (left > 0)
                left--;
            else if (result_ch.ready !== 1'b1) begin
                result_ch.ready <= 1'b1;
                if ($urandom_range(0, 9) == 0)
                    left = $urandom_range(100, 300);
                else
                    left = $urandom_range(0, 30);
            end
            else begin
                left = idle_len(burst);
                if (left > 0) begin
                    result_ch.ready <= 1'b0;
                    left--;
                end
            end
        end
    end

    // Output monitor
    always @(posedge clk)
    begin : result_mon
        result_t got;
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
            got.call_state     = result_ch.call_state;
            got.join_relay     = result_ch.join_relay;
            got.bell_relay     = result_ch.bell_relay;
            got.tone_command   = result_ch.tone_command;
            got.send_caller_id = result_ch.send_caller_id;
            sb.check_result(got);
        end
    end

    // Stimulus
    initial
    begin : stimulus
        int start;
        rst_n                   <= 1'b0;
        tick_ch.valid           <= 1'b0;
        tick_ch.caller_hook_raw <= 1'b0;
        tick_ch.dest_hook_raw   <= 1'b0;
        tick_ch.digits_received <= 1'b0;
        cfg_ch.valid            <= 1'b0;
        cfg_ch.index            <= REG_DEBOUNCE;
        cfg_ch.data             <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: every raw combination, then one slow call attempt
        for (int i = 0; i < 8; i++)
            send_tick(i[2], i[1], i[0]);
        hold_lines(1, 0, DEBOUNCE_DEF + 3, 0, 0);
        hold_lines(1, 0, 1, 100, 0);
        hold_lines(1, 0, 20, 0, 0);
        hold_lines(0, 0, DEBOUNCE_DEF + 3, 0, 0);
        settle();

        // zero thresholds: walk every state and tone command
        set_regs('0, '0, '0, '0);
        hold_lines(1, 0, 2, 0, 0);      // wait for dial, dial tone
        hold_lines(1, 0, 1, 100, 0);    // calling: ringback, first toggle
        hold_lines(1, 0, 2, 0, 0);      // more toggles, caller id
        hold_lines(1, 1, 2, 0, 0);      // answered
        hold_lines(0, 1, 3, 0, 0);      // caller down: busy cadence
        hold_lines(0, 0, 2, 0, 0);      // idle
        hold_lines(1, 1, 2, 0, 0);      // idle straight to busy
        hold_lines(0, 0, 2, 0, 0);
        hold_lines(1, 0, 2, 0, 0);      // hang up while waiting
        hold_lines(0, 0, 2, 0, 0);
        hold_lines(1, 0, 2, 0, 0);      // hang up while calling
        hold_lines(1, 0, 1, 100, 0);
        hold_lines(0, 0, 2, 0, 0);
        settle();

        // thresholds at the timer maximum never expire
        set_regs('1, '1, '1, '1);
        noise(30);
        settle();
        set_regs(16'd2, '1, '1, '1);
        call_flow(2);
        busy_flow(2);
        settle();

        start = ticks_sent;
        while (ticks_sent - start < RANDOM_TICKS)
            random_phase();

        settle();
        if (sb.due_results.size() != 0)
            sb.report($sformatf("%0d output items never arrived", sb.due_results.size()));
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #3000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: two_line_call_controller_core.f
+incdir+rtl/core
rtl/core/tlcc_pkg.sv
rtl/core/tlcc_ifs.sv
rtl/core/tlcc_debounce.sv
rtl/core/tlcc_engine.sv
rtl/core/two_line_call_controller_core.sv
tb/two_line_call_controller_core_tb.sv
